// ===== rtl/pckbd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pckbd_pkg
// Shared types and constants for the PC system port and keyboard controller.
// ----------------------------------------------------------------------------
package pckbd_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;

  // item kinds carried in tuser
  typedef enum logic [1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_TICK  = 2'd2,
    FUNC_KEY   = 2'd3
  } func_t;

  // decoded port offsets (address minus 0x60)
  localparam logic [2:0] OFF_DATA   = 3'd0;
  localparam logic [2:0] OFF_SYSTEM = 3'd1;
  localparam logic [2:0] OFF_DIP    = 3'd2;
  localparam logic [2:0] OFF_CMD    = 3'd4;

  // configuration register indexes
  localparam logic CFG_AT_MODE = 1'b0;
  localparam logic CFG_DIP     = 1'b1;

  // controller commands
  localparam logic [7:0] CMD_DISABLE      = 8'hAD;
  localparam logic [7:0] CMD_ENABLE       = 8'hAE;
  localparam logic [7:0] CMD_READ_INPUT   = 8'hD0;
  localparam logic [7:0] CMD_WRITE_OUTPUT = 8'hD1;

  localparam logic [7:0] KBD_RESET_CODE = 8'hAA;
  localparam logic [7:0] SYS_PORT_RST   = 8'd14;
  localparam logic [7:0] DIP_RST        = 8'h02;
  localparam logic [7:0] SYS_READ_MASK  = 8'hEF;
  localparam logic [7:0] SYS_RESET_BITS = 8'hC0;

  // status bits
  localparam int ST_DATA_READY = 0;
  localparam int ST_CMD_READY  = 1;

  typedef struct packed {
    logic push;      // append at tail
    logic force_wr;  // overwrite last entry of a full queue
    logic pop;       // drop head
    logic clear;     // empty the queue
  } q_ctl_t;

  typedef struct packed {
    logic       empty;
    logic       full;
    logic [7:0] head_data;
  } q_stat_t;

endpackage

// ===== rtl/pckbd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pckbd_queue
// Scancode ring buffer with a registered head read and write forwarding.
// ----------------------------------------------------------------------------
module pckbd_queue import pckbd_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  q_ctl_t     ctl,
  input  logic [7:0] key,
  output q_stat_t    stat
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = CW + 1;

  logic [7:0]    mem [QUEUE_DEPTH];
  logic [AW-1:0] head;
  logic [AW-1:0] head_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [7:0]    head_data;

  logic [SW-1:0] tail_sum;
  logic [AW-1:0] tail_addr;
  logic [AW-1:0] last_addr;
  logic [AW-1:0] waddr;
  logic          we;

  assign tail_sum  = SW'(head) + SW'(count);
  assign tail_addr = (tail_sum >= SW'(QUEUE_DEPTH)) ?
                     AW'(tail_sum - SW'(QUEUE_DEPTH)) : AW'(tail_sum);
  assign last_addr = (head == '0) ? AW'(QUEUE_DEPTH - 1) : head - 1'b1;

  assign we    = ctl.push | ctl.force_wr;
  assign waddr = ctl.push ? tail_addr : last_addr;

  always_comb begin
    head_next  = head;
    count_next = count;
    if (ctl.clear) begin
      count_next = '0;
    end else if (ctl.pop) begin
      head_next  = (head == AW'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
      count_next = count - 1'b1;
    end else if (ctl.push) begin
      count_next = count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      count <= count_next;
    end
  end

  // keep the head entry staged; forward a write that lands on it
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= key;
    end
    if (we && waddr == head_next) begin
      head_data <= key;
    end else begin
      head_data <= mem[head_next];
    end
  end

  assign stat.empty     = (count == '0);
  assign stat.full      = (count == CW'(QUEUE_DEPTH));
  assign stat.head_data = head_data;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    ctl.push |-> !stat.full)
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    ctl.pop |-> !stat.empty)
    else $error("pop from empty queue");
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    ctl.clear |=> stat.empty)
    else $error("queue not empty after clear");
`endif

endmodule

// ===== rtl/pc_keyboard_port_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pc_keyboard_port_controller
// System port 0x61, switch port, keyboard data/status and AT command port,
// with a scancode queue feeding the data port on ticks.
// ----------------------------------------------------------------------------
//  channel   dir  signals                      beat
//  s_*       in   s_tvalid/s_tready/s_tdata/   one port read, write, tick or
//                 s_tuser                      key event
//  m_*       out  m_tvalid/m_tready/m_tdata    one result per input beat
//  cfg_*     in   cfg_we/cfg_index/cfg_data    register write, no wait
//
//  Each beat is decoded and applied to the state in the cycle it is taken;
//  its result sits in the output register in the next cycle. One beat a cycle.
//  The queue head is staged in a register so a tick reads it without delay.
//  A stalled output holds its beat; input is taken while the output register
//  is empty or being drained. rst is synchronous and empties the queue.
// ----------------------------------------------------------------------------
module pc_keyboard_port_controller import pckbd_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // port_offset[2:0], write_data[10:3],
                                 // key_code[18:11], force_req[19], zero
  input  logic [1:0]  s_tuser,   // func[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // read_data[7:0], key_accepted[8],
                                 // irq_raise[9], a20_write[10],
                                 // a20_enable[11], speaker_change[12],
                                 // speaker_on[13], turbo_on[14], zero
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  logic       at_mode;
  logic [7:0] dip_switches;

  logic [7:0] data_byte,    data_byte_next;
  logic [1:0] status_byte,  status_byte_next;
  logic [7:0] system_port,  system_port_next;
  logic [7:0] last_command, last_command_next;
  logic [7:0] output_byte,  output_byte_next;
  logic       refresh_bit,  refresh_bit_next;
  logic       keys_enabled, keys_enabled_next;
  logic       speaker_state, speaker_state_next;
  logic       turbo_state,  turbo_state_next;

  logic       s_accept;
  func_t      func;
  logic [2:0] port_offset;
  logic [7:0] write_data;
  logic [7:0] key_code;
  logic       force_req;

  logic [7:0] rd;
  logic       acc, irq, a20w, spkc, spk;
  q_ctl_t     qctl;
  q_ctl_t     qctl_gated;
  q_stat_t    qstat;

  assign s_tready    = !m_tvalid || m_tready;
  assign s_accept    = s_tvalid && s_tready;
  assign func        = func_t'(s_tuser);
  assign port_offset = s_tdata[2:0];
  assign write_data  = s_tdata[10:3];
  assign key_code    = s_tdata[18:11];
  assign force_req   = s_tdata[19];

  always_comb begin
    data_byte_next     = data_byte;
    status_byte_next   = status_byte;
    system_port_next   = system_port;
    last_command_next  = last_command;
    output_byte_next   = output_byte;
    refresh_bit_next   = refresh_bit;
    keys_enabled_next  = keys_enabled;
    speaker_state_next = speaker_state;
    turbo_state_next   = turbo_state;
    rd   = '0;
    acc  = 1'b0;
    irq  = 1'b0;
    a20w = 1'b0;
    spkc = 1'b0;
    spk  = 1'b0;
    qctl = '0;
    unique case (func)
      FUNC_READ: begin
        case (port_offset)
          OFF_DATA: begin
            rd               = data_byte;
            data_byte_next   = '0;
            status_byte_next = '0;
          end
          OFF_SYSTEM: begin
            refresh_bit_next = refresh_bit ^ at_mode;
            rd = (system_port & SYS_READ_MASK) | {3'b000, refresh_bit_next, 4'b0000};
          end
          OFF_DIP: rd = dip_switches;
          OFF_CMD: rd = {6'b000000, status_byte};
          default: rd = '0;
        endcase
      end
      FUNC_WRITE: begin
        case (port_offset)
          OFF_DATA: begin
            if (at_mode && !keys_enabled && last_command == CMD_WRITE_OUTPUT) begin
              last_command_next = '0;
              output_byte_next  = write_data;
              a20w              = 1'b1;
            end
          end
          OFF_SYSTEM: begin
            spk = &write_data[1:0];
            if (spk != speaker_state) begin
              speaker_state_next = spk;
              spkc               = 1'b1;
            end
            turbo_state_next = write_data[2];
            // keyboard reset: clock/clear bits rise from both low
            if ((system_port & SYS_RESET_BITS) == '0 &&
                (write_data & SYS_RESET_BITS) != '0) begin
              qctl.clear       = 1'b1;
              data_byte_next   = KBD_RESET_CODE;
              status_byte_next = 2'b11;
              irq              = 1'b1;
            end
            system_port_next = write_data;
          end
          OFF_CMD: begin
            if (at_mode) begin
              last_command_next = write_data;
              if (write_data == CMD_ENABLE) begin
                keys_enabled_next = 1'b1;
              end else if (write_data == CMD_DISABLE) begin
                keys_enabled_next = 1'b0;
              end
            end
          end
          default: ;
        endcase
      end
      FUNC_TICK: begin
        status_byte_next[ST_CMD_READY] = 1'b1;
        if (keys_enabled) begin
          if (!qstat.empty && !status_byte[ST_DATA_READY]) begin
            status_byte_next[ST_DATA_READY] = 1'b1;
            data_byte_next = qstat.head_data;
            qctl.pop       = 1'b1;
            irq            = 1'b1;
          end
        end else if (last_command == CMD_READ_INPUT) begin
          status_byte_next[ST_DATA_READY] = 1'b1;
          data_byte_next = output_byte;
        end
      end
      FUNC_KEY: begin
        if (!qstat.full) begin
          qctl.push = 1'b1;
          acc       = 1'b1;
        end else if (force_req) begin
          qctl.force_wr = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign qctl_gated = s_accept ? qctl : '0;

  pckbd_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .ctl  (qctl_gated),
    .key  (key_code),
    .stat (qstat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      at_mode      <= 1'b0;
      dip_switches <= DIP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_AT_MODE: at_mode      <= cfg_data[0];
        CFG_DIP:     dip_switches <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      data_byte     <= '0;
      status_byte   <= '0;
      system_port   <= SYS_PORT_RST;
      last_command  <= '0;
      output_byte   <= '0;
      refresh_bit   <= 1'b0;
      keys_enabled  <= 1'b1;
      speaker_state <= 1'b0;
      turbo_state   <= 1'b0;
    end else if (s_accept) begin
      data_byte     <= data_byte_next;
      status_byte   <= status_byte_next;
      system_port   <= system_port_next;
      last_command  <= last_command_next;
      output_byte   <= output_byte_next;
      refresh_bit   <= refresh_bit_next;
      keys_enabled  <= keys_enabled_next;
      speaker_state <= speaker_state_next;
      turbo_state   <= turbo_state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // result beat: hold while stalled
  always_ff @(posedge clk) begin
    if (s_accept) begin
      m_tdata <= {1'b0, turbo_state_next, speaker_state_next, spkc,
                  output_byte_next[1], a20w, irq, acc, rd};
    end
  end

endmodule

// ===== test/pc_keyboard_port_controller_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pc_keyboard_port_controller_tb
// Self-checking bench for the system port and keyboard controller. Directed
// items walk the ports, commands, keyboard reset and A20 path in XT and AT
// mode. Random phases follow, each with its own register setting, mixing key
// bursts, drains, command sequences and noise. Both stream sides idle at
// random. A predictor tracks the controller state and checks every result.
// ----------------------------------------------------------------------------
module pc_keyboard_port_controller_tb;
  import pckbd_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT  = 2000;
  localparam int PHASE_ITEMS = 300;

  typedef struct packed {
    logic [7:0] rd;
    logic       acc;
    logic       irq;
    logic       a20w;
    logic       a20en;
    logic       spkc;
    logic       spk;
    logic       turbo;
  } kbd_result_t;

  class ppi_state_model;
    logic        at_mode = 1'b0;
    logic [7:0]  dip = DIP_RST;
    logic [7:0]  data_byte = '0;
    logic [7:0]  status_byte = '0;
    logic [7:0]  sys_port = SYS_PORT_RST;
    logic [7:0]  last_cmd = '0;
    logic [7:0]  out_byte = '0;
    logic        refresh = 1'b0;
    logic        keys_en = 1'b1;
    logic        spk = 1'b0;
    logic        turbo = 1'b0;
    logic [7:0]  keys[$];
    kbd_result_t pending_results[$];
    int fails = 0;
    int items = 0;
    int checked = 0;
    int kbd_resets = 0;
    int a20_writes = 0;
    int dropped_keys = 0;
    int forced_keys = 0;
    int irqs = 0;

    function void set_config(logic at, logic [7:0] sw);
      at_mode = at;
      dip = sw;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void note_item(func_t fn, logic [2:0] off, logic [7:0] wd,
                            logic [7:0] kc, logic frc);
      kbd_result_t r;
      r = '0;
      items++;
      case (fn)
        FUNC_READ: begin
          if (off == OFF_DATA) begin
            r.rd = data_byte;
            data_byte = '0;
            status_byte = '0;
          end else if (off == OFF_SYSTEM) begin
            if (at_mode) refresh = ~refresh;
            r.rd = (sys_port & SYS_READ_MASK) | {3'b000, refresh, 4'b0000};
          end else if (off == OFF_DIP) begin
            r.rd = dip;
          end else if (off == OFF_CMD) begin
            r.rd = status_byte;
          end
        end
        FUNC_WRITE: begin
          if (off == OFF_DATA) begin
            if (at_mode && !keys_en && last_cmd == CMD_WRITE_OUTPUT) begin
              last_cmd = '0;
              out_byte = wd;
              r.a20w = 1'b1;
              a20_writes++;
            end
          end else if (off == OFF_SYSTEM) begin
            if ((wd[1:0] == 2'b11) != spk) begin
              spk = ~spk;
              r.spkc = 1'b1;
            end
            turbo = wd[2];
            // keyboard reset on a rising top bit pair
            if ((sys_port & SYS_RESET_BITS) == 0 && (wd & SYS_RESET_BITS) != 0) begin
              keys.delete();
              data_byte = KBD_RESET_CODE;
              status_byte = '0;
              status_byte[ST_DATA_READY] = 1'b1;
              status_byte[ST_CMD_READY] = 1'b1;
              r.irq = 1'b1;
              kbd_resets++;
            end
            sys_port = wd;
          end else if (off == OFF_CMD && at_mode) begin
            last_cmd = wd;
            if (wd == CMD_ENABLE) keys_en = 1'b1;
            else if (wd == CMD_DISABLE) keys_en = 1'b0;
          end
        end
        FUNC_TICK: begin
          status_byte[ST_CMD_READY] = 1'b1;
          if (keys_en) begin
            if (keys.size() != 0 && !status_byte[ST_DATA_READY]) begin
              status_byte[ST_DATA_READY] = 1'b1;
              data_byte = keys.pop_front();
              r.irq = 1'b1;
            end
          end else if (last_cmd == CMD_READ_INPUT) begin
            status_byte[ST_DATA_READY] = 1'b1;
            data_byte = out_byte;
          end
        end
        default: begin
          if (keys.size() < QUEUE_DEPTH_DEF) begin
            keys.push_back(kc);
            r.acc = 1'b1;
          end else begin
            dropped_keys++;
            if (frc) begin
              keys[QUEUE_DEPTH_DEF-1] = kc;
              forced_keys++;
            end
          end
        end
      endcase
      if (r.irq) irqs++;
      r.a20en = out_byte[1];
      r.spk = spk;
      r.turbo = turbo;
      pending_results.push_back(r);
    endfunction

    function void cmp(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        fails++;
      end
    endfunction

    function void check_result(logic [15:0] d);
      kbd_result_t e;
      if (pending_results.size() == 0) begin
        $error("result beat with nothing pending: tdata %h", d);
        fails++;
        return;
      end
      e = pending_results.pop_front();
      checked++;
      cmp("read_data", 32'(e.rd), 32'(d[7:0]));
      cmp("key_accepted", 32'(e.acc), 32'(d[8]));
      cmp("irq_raise", 32'(e.irq), 32'(d[9]));
      cmp("a20_write", 32'(e.a20w), 32'(d[10]));
      cmp("a20_enable", 32'(e.a20en), 32'(d[11]));
      cmp("speaker_change", 32'(e.spkc), 32'(d[12]));
      cmp("speaker_on", 32'(e.spk), 32'(d[13]));
      cmp("turbo_on", 32'(e.turbo), 32'(d[14]));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // port_offset[2:0], write_data[10:3],
                               // key_code[18:11], force_req[19], zero
  logic [1:0]  s_tuser = '0;   // func[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // read_data[7:0], key_accepted[8], irq_raise[9],
                               // a20_write[10], a20_enable[11],
                               // speaker_change[12], speaker_on[13],
                               // turbo_on[14], zero
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [7:0]  cfg_data = '0;

  ppi_state_model model = new();
  int tx_gap_pct = 0;
  int rx_stall_pct = 0;
  bit hold_req = 1'b0;

  pc_keyboard_port_controller u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready)
      model.note_item(func_t'(s_tuser), s_tdata[2:0], s_tdata[10:3], s_tdata[18:11],
                      s_tdata[19]);
    if (!rst && m_tvalid && m_tready)
      model.check_result(m_tdata);
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin : sink
    int idle_left;
    idle_left = 0;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_left > 0) begin
        m_tready <= 1'b0;
        idle_left--;
      end else if (rx_stall_pct != 0 && $urandom_range(99) < rx_stall_pct) begin
        idle_left = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
        m_tready <= 1'b0;
        idle_left--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle = 0;
      else idle++;
    end
    $display("stalled for %0d cycles with %0d results outstanding", IDLE_LIMIT,
             model.pending());
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_item(func_t fn, logic [2:0] off, logic [7:0] wd, logic [7:0] kc,
                           logic frc);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata <= {4'b0000, frc, kc, wd, off};
    s_tuser <= fn;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (tx_gap_pct != 0 && $urandom_range(99) < tx_gap_pct) begin
      gap = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic port_read(logic [2:0] off);
    send_item(FUNC_READ, off, 8'($urandom_range(255)), 8'($urandom_range(255)),
              1'($urandom_range(1)));
  endtask

  task automatic port_write(logic [2:0] off, logic [7:0] wd);
    send_item(FUNC_WRITE, off, wd, 8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  task automatic tick();
    send_item(FUNC_TICK, 3'($urandom_range(7)), 8'($urandom_range(255)),
              8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  task automatic key_event(logic [7:0] kc, logic frc);
    send_item(FUNC_KEY, 3'($urandom_range(7)), 8'($urandom_range(255)), kc, frc);
  endtask

  // drop valid, let every result come back, then settle
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (model.pending() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_regs(logic at, logic [7:0] sw);
    cfg_we <= 1'b1;
    cfg_index <= CFG_AT_MODE;
    cfg_data <= {7'd0, at};
    @(posedge clk);
    cfg_index <= CFG_DIP;
    cfg_data <= sw;
    @(posedge clk);
    cfg_we <= 1'b0;
    model.set_config(at, sw);
  endtask

  task automatic random_sequence();
    int pick;
    int n;
    logic [7:0] cmd;
    pick = $urandom_range(99);
    if (pick < 15) begin
      send_item(func_t'(2'($urandom_range(3))), 3'($urandom_range(7)),
                8'($urandom_range(255)), 8'($urandom_range(255)), 1'($urandom_range(1)));
    end else if (pick < 40) begin
      n = $urandom_range(20, 1);
      repeat (n) key_event(8'($urandom_range(255)), 1'($urandom_range(1)));
    end else if (pick < 60) begin
      n = $urandom_range(4, 1);
      repeat (n) begin
        tick();
        if ($urandom_range(1)) port_read(OFF_CMD);
        port_read(OFF_DATA);
      end
    end else if (pick < 75) begin
      // A20 gate update and read-back through the command port
      port_write(OFF_CMD, CMD_DISABLE);
      port_write(OFF_CMD, CMD_WRITE_OUTPUT);
      port_write(OFF_DATA, 8'($urandom_range(255)));
      port_write(OFF_CMD, CMD_READ_INPUT);
      tick();
      port_read(OFF_DATA);
      if ($urandom_range(4) != 0) port_write(OFF_CMD, CMD_ENABLE);
    end else if (pick < 88) begin
      port_write(OFF_SYSTEM, 8'($urandom_range(255)) & 8'h3F);
      if ($urandom_range(1)) port_write(OFF_SYSTEM, 8'($urandom_range(255)));
      port_read(OFF_SYSTEM);
      if ($urandom_range(1)) port_read(OFF_DATA);
      port_read(OFF_DIP);
    end else begin
      // command sequences left half done or out of order
      case ($urandom_range(3))
        0: cmd = CMD_DISABLE;
        1: cmd = CMD_READ_INPUT;
        2: cmd = CMD_WRITE_OUTPUT;
        default: cmd = 8'($urandom_range(255));
      endcase
      port_write(OFF_CMD, cmd);
      port_write(OFF_DATA, 8'($urandom_range(255)));
      tick();
      port_read(OFF_CMD);
      port_read(OFF_DATA);
      if ($urandom_range(1)) port_write(OFF_CMD, CMD_ENABLE);
    end
  endtask

  initial begin : stimulus
    int at_sel[5];
    int tx_sel[5];
    int rx_sel[5];
    int start;
    logic [7:0] sw;
    at_sel = '{0, 1, 1, 0, 1};
    tx_sel = '{30, 0, 30, 60, 20};
    rx_sel = '{30, 0, 50, 10, 20};
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // XT mode at reset settings
    tx_gap_pct = 20;
    rx_stall_pct = 20;
    port_read(OFF_DIP);
    port_read(OFF_SYSTEM);
    port_read(3'd7);
    port_read(3'd3);
    port_write(OFF_DATA, 8'hFF);
    port_write(OFF_CMD, CMD_DISABLE);
    port_write(3'd5, 8'hFF);
    key_event(8'h00, 1'b0);
    key_event(8'hFF, 1'b1);
    tick();
    port_read(OFF_CMD);
    port_read(OFF_DATA);
    tick();
    port_read(OFF_DATA);
    port_write(OFF_SYSTEM, 8'h03);
    port_write(OFF_SYSTEM, 8'hFC);
    port_read(OFF_DATA);
    port_write(OFF_SYSTEM, 8'h00);
    port_read(OFF_SYSTEM);
    drain_results();

    // AT command port
    write_regs(1'b1, 8'h81);
    port_write(OFF_CMD, CMD_DISABLE);
    tick();
    port_write(OFF_CMD, CMD_WRITE_OUTPUT);
    port_write(OFF_DATA, 8'hFF);
    port_write(OFF_CMD, CMD_READ_INPUT);
    tick();
    port_read(OFF_DATA);
    port_read(OFF_SYSTEM);
    port_read(OFF_SYSTEM);
    port_write(OFF_CMD, CMD_ENABLE);
    port_write(OFF_DATA, 8'h00);
    drain_results();

    for (int ph = 0; ph < 5; ph++) begin
      sw = (ph == 0) ? 8'h00 : (ph == 1) ? 8'hFF : 8'($urandom_range(255));
      write_regs(at_sel[ph][0], sw);
      tx_gap_pct = tx_sel[ph];
      rx_stall_pct = rx_sel[ph];
      start = model.items;
      if (ph == 2) begin
        // hold the output off and keep offering, so the input backs up
        hold_req = 1'b1;
        tx_gap_pct = 0;
        repeat (40) key_event(8'($urandom_range(255)), 1'($urandom_range(1)));
        tx_gap_pct = tx_sel[ph];
      end
      while (model.items - start < PHASE_ITEMS) random_sequence();
      drain_results();
    end

    $display("items %0d, results %0d, keyboard resets %0d, A20 writes %0d, irqs %0d",
             model.items, model.checked, model.kbd_resets, model.a20_writes, model.irqs);
    $display("keys refused on a full queue %0d, of them overwrites %0d", model.dropped_keys,
             model.forced_keys);
    if (model.fails == 0 && model.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/pckbd_pkg.sv
rtl/pckbd_queue.sv
rtl/pc_keyboard_port_controller.sv
test/pc_keyboard_port_controller_tb.sv
